[rtl/slx_pkg.sv]
// Shared types, constants and keyword tables for the source lexer.
`timescale 1ns / 1ps
`default_nettype none
package slx_pkg;

  localparam int NUMBER_BUFFER = 256;
  localparam int NLEN_W = $clog2(NUMBER_BUFFER);
  localparam int LINE_W = 24;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam int KW_N = 10;

  // result queue: one step may add three results
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW = $clog2(RQ_DEPTH);

  localparam logic [1:0] RK_CHAR  = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;
  localparam logic [1:0] RK_END   = 2'd3;

  localparam logic ERR_NEWLINE = 1'b0;
  localparam logic ERR_UNKNOWN = 1'b1;

  localparam logic [5:0] T_LPAREN = 6'd0;
  localparam logic [5:0] T_RPAREN = 6'd1;
  localparam logic [5:0] T_LBRACK = 6'd2;
  localparam logic [5:0] T_RBRACK = 6'd3;
  localparam logic [5:0] T_LBRACE = 6'd4;
  localparam logic [5:0] T_RBRACE = 6'd5;
  localparam logic [5:0] T_SEMI   = 6'd6;
  localparam logic [5:0] T_COMMA  = 6'd7;
  localparam logic [5:0] T_DOT    = 6'd8;
  localparam logic [5:0] T_ASSIGN = 6'd9;
  localparam logic [5:0] T_PLUS   = 6'd10;
  localparam logic [5:0] T_MINUS  = 6'd11;
  localparam logic [5:0] T_MUL    = 6'd12;
  localparam logic [5:0] T_DIVIDE = 6'd13;
  localparam logic [5:0] T_MOD    = 6'd14;
  localparam logic [5:0] T_INC    = 6'd15;
  localparam logic [5:0] T_DEC    = 6'd16;
  localparam logic [5:0] T_EQ     = 6'd17;
  localparam logic [5:0] T_EQQ    = 6'd18;
  localparam logic [5:0] T_GT     = 6'd19;
  localparam logic [5:0] T_GE     = 6'd20;
  localparam logic [5:0] T_LT     = 6'd21;
  localparam logic [5:0] T_LE     = 6'd22;
  localparam logic [5:0] T_NE     = 6'd23;
  localparam logic [5:0] T_NOT    = 6'd24;
  localparam logic [5:0] T_AND    = 6'd25;
  localparam logic [5:0] T_OR     = 6'd26;
  localparam logic [5:0] T_STRING = 6'd27;
  localparam logic [5:0] T_INT    = 6'd28;
  localparam logic [5:0] T_FLOAT  = 6'd29;
  localparam logic [5:0] T_KW0    = 6'd30;
  localparam logic [5:0] T_IDENT  = 6'd40;

  localparam logic [2:0] HO_NONE = 3'd0;
  localparam logic [2:0] HO_PLUS = 3'd1;
  localparam logic [2:0] HO_MIN  = 3'd2;
  localparam logic [2:0] HO_EQ   = 3'd3;
  localparam logic [2:0] HO_EQ2  = 3'd4;
  localparam logic [2:0] HO_GT   = 3'd5;
  localparam logic [2:0] HO_LT   = 3'd6;
  localparam logic [2:0] HO_BANG = 3'd7;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FLOAT, MODE_STRING, MODE_COMMENT,
    MODE_SLASH, MODE_AMP, MODE_PIPE, MODE_HELD, MODE_HALTED
  } mode_t;

  typedef struct packed {
    logic              last;
    logic [LINE_W-1:0] line;
    logic              err;
    logic [5:0]        ttype;
    logic [7:0]        ch;
    logic [1:0]        kind;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] ch, logic [5:0] ttype,
                                  logic err, logic [LINE_W-1:0] line);
    res_t r;
    r.last  = 1'b0;
    r.line  = line;
    r.err   = err;
    r.ttype = ttype;
    r.ch    = ch;
    r.kind  = kind;
    return r;
  endfunction

  function automatic logic [3:0] kw_len(int k);
    logic [3:0] l;
    case (k)
      0: l = 4'd3;
      1: l = 4'd8;
      2: l = 4'd6;
      3: l = 4'd2;
      4: l = 4'd4;
      5: l = 4'd5;
      6: l = 4'd3;
      7: l = 4'd9;
      8: l = 4'd3;
      default: l = 4'd5;
    endcase
    return l;
  endfunction

  // character p of keyword k; zero beyond its end
  function automatic logic [7:0] kw_char(int k, logic [3:0] p);
    logic [71:0] s;
    logic [3:0] l;
    logic [3:0] idx;
    case (k)
      0: s = 72'("var");
      1: s = 72'("function");
      2: s = 72'("return");
      3: s = 72'("if");
      4: s = 72'("else");
      5: s = 72'("while");
      6: s = 72'("for");
      7: s = 72'("newobject");
      8: s = 72'("nil");
      default: s = 72'("break");
    endcase
    l = kw_len(k);
    idx = l - 4'd1 - p;
    if (p >= l) return 8'h00;
    return s[8*idx +: 8];
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c == "_") || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage
`default_nettype wire

[rtl/script_source_lexer.sv]
// Top level of the streaming source lexer.
// Source bytes enter on the in_ stream, one per transaction; a zero byte ends
// the source, flushes any open token and yields an end-of-source result.
// Results leave on the out_ stream: out_tuser carries the result kind
// (content character, token complete, error, end of source), out_tdata the
// character, token type, error code and line, and out_tlast marks the last
// result caused by one source byte. A byte may cause none to three results.
// An accepted byte is held in the input register until the lexer takes it,
// updates its state and writes its results into an eight-entry result queue;
// the first of those results is then shown on out_ from the head of the queue.
// A byte is taken every cycle while the queue has room for three results;
// sustained throughput is one byte per cycle, bounded on the output side by
// one result per cycle. If the receiver stalls, the queue fills and in_tready
// drops; nothing is lost. Reset (rst_n low, synchronous) empties the queue
// and returns the lexer to line one, between tokens, with no error recorded.
`timescale 1ns / 1ps
`default_nettype none
module script_source_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] source_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [7:0] char_value, [13:8] token_type,
                                        // [14] error_code, [38:15] line_number
  output logic [1:0]       out_tuser,   // [1:0] result_kind
  output logic             out_tlast
);

  logic                  in_v_r;
  logic [7:0]            in_b_r;
  logic                  room3;
  logic                  step;
  slx_pkg::res_t [2:0]   res;
  logic [1:0]            res_cnt;
  slx_pkg::res_t         head;

  assign step      = in_v_r && room3;
  assign in_tready = !in_v_r || room3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_b_r <= in_tdata;
  end

  slx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .byte_in   (in_b_r),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  slx_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (res),
    .wr_cnt   (step ? res_cnt : 2'd0),
    .room3    (room3),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {1'b0, head.line, head.err, head.ttype, head.ch};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
`default_nettype wire

[rtl/slx_core.sv]
// Lexer state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
module slx_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire logic [7:0]          byte_in,
  output slx_pkg::res_t [2:0]      res_o,
  output logic [1:0]               res_cnt_o
);

  slx_pkg::mode_t                     mode_r, mode_nxt;
  logic [2:0]                         held_r, held_nxt;
  logic                               esc_r, esc_nxt;
  logic                               sop_r, sop_nxt;
  logic [slx_pkg::LINE_W-1:0]         cur_r, cur_nxt;
  logic [slx_pkg::LINE_W-1:0]         tok_r, tok_nxt;
  logic [slx_pkg::NLEN_W-1:0]         nlen_r, nlen_nxt;
  logic [3:0]                         idl_r, idl_nxt;
  logic [slx_pkg::KW_N-1:0]           kw_r, kw_nxt;
  logic                               errs_r, errs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slx_pkg::MODE_IDLE;
      held_r <= slx_pkg::HO_NONE;
      esc_r  <= 1'b0;
      sop_r  <= 1'b0;
      cur_r  <= slx_pkg::LINE_W'(1);
      tok_r  <= slx_pkg::LINE_W'(1);
      nlen_r <= '0;
      idl_r  <= '0;
      kw_r   <= '1;
      errs_r <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      esc_r  <= esc_nxt;
      sop_r  <= sop_nxt;
      cur_r  <= cur_nxt;
      tok_r  <= tok_nxt;
      nlen_r <= nlen_nxt;
      idl_r  <= idl_nxt;
      kw_r   <= kw_nxt;
      errs_r <= errs_nxt;
    end
  end

  always_comb begin
    slx_pkg::res_t r [4];
    logic [1:0] n;
    logic do_idle;
    logic [7:0] c;
    logic [5:0] ityp;
    logic [5:0] pair_t, single_t;
    logic       match;
    logic       do_add;
    c = byte_in;
    for (int i = 0; i < 4; i++) r[i] = '0;
    n = '0;
    do_idle = 1'b0;
    do_add = 1'b0;
    ityp = slx_pkg::T_IDENT;
    pair_t = '0;
    single_t = '0;
    match = 1'b0;
    mode_nxt = mode_r; held_nxt = held_r; esc_nxt = esc_r; sop_nxt = sop_r;
    cur_nxt = cur_r; tok_nxt = tok_r; nlen_nxt = nlen_r; idl_nxt = idl_r;
    kw_nxt = kw_r; errs_nxt = errs_r;

    for (int k = slx_pkg::KW_N - 1; k >= 0; k--) begin
      if (kw_r[k] && (slx_pkg::kw_len(k) == idl_r)) ityp = slx_pkg::T_KW0 + 6'(k);
    end

    unique case (mode_r)
      slx_pkg::MODE_IDLE: do_idle = 1'b1;
      slx_pkg::MODE_IDENT: begin
        if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c)) begin
          do_add = 1'b1;
        end else begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, ityp, 1'b0, tok_nxt); n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      slx_pkg::MODE_INT, slx_pkg::MODE_FLOAT: begin
        if ((slx_pkg::is_digit(c) || c == ".") &&
            (nlen_r < slx_pkg::NLEN_W'(slx_pkg::NUMBER_BUFFER - 1))) begin
          if (c == ".") mode_nxt = slx_pkg::MODE_FLOAT;
          nlen_nxt = nlen_r + 1'b1;
          r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
        end else begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0,
                   (mode_r == slx_pkg::MODE_FLOAT) ? slx_pkg::T_FLOAT : slx_pkg::T_INT,
                   1'b0, tok_nxt);
          n = n + 2'd1;
          nlen_nxt = '0;
          do_idle = 1'b1;
        end
      end
      slx_pkg::MODE_STRING: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (c == 8'h00) begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, "\\", '0, 1'b0, tok_nxt); n = n + 2'd1;
            do_idle = 1'b1;
          end else if (c == 8'h0a) begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_ERROR, '0, '0, slx_pkg::ERR_NEWLINE, cur_nxt);
            n = n + 2'd1;
            mode_nxt = slx_pkg::MODE_HALTED; errs_nxt = 1'b1;
          end else if (c == "n") begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, 8'h0a, '0, 1'b0, tok_nxt); n = n + 2'd1;
          end else if (c == "r") begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, 8'h0d, '0, 1'b0, tok_nxt); n = n + 2'd1;
          end else if (c == "t") begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, 8'h09, '0, 1'b0, tok_nxt); n = n + 2'd1;
          end else if (c == "\"") begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
          end else begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, "\\", '0, 1'b0, tok_nxt); n = n + 2'd1;
            r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
          end
        end else if (c == 8'h00) begin
          do_idle = 1'b1;
        end else if (c == 8'h0a) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_ERROR, '0, '0, slx_pkg::ERR_NEWLINE, cur_nxt);
          n = n + 2'd1;
          mode_nxt = slx_pkg::MODE_HALTED; errs_nxt = 1'b1;
        end else if (c == "\"") begin
          mode_nxt = slx_pkg::MODE_IDLE;
        end else if (c == "\\") begin
          esc_nxt = 1'b1;
        end else begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
        end
      end
      slx_pkg::MODE_COMMENT: begin
        if (c == 8'h0a || c == 8'h00) do_idle = 1'b1;
      end
      slx_pkg::MODE_SLASH: begin
        if (c == "/") begin
          mode_nxt = slx_pkg::MODE_COMMENT;
        end else begin
          if (sop_nxt) begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_STRING, 1'b0, tok_nxt);
            n = n + 2'd1;
            sop_nxt = 1'b0;
          end
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_DIVIDE, 1'b0, cur_nxt);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      slx_pkg::MODE_AMP, slx_pkg::MODE_PIPE: begin
        if (c == ((mode_r == slx_pkg::MODE_AMP) ? 8'("&") : 8'("|"))) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0,
                   (mode_r == slx_pkg::MODE_AMP) ? slx_pkg::T_AND : slx_pkg::T_OR,
                   1'b0, tok_nxt);
          n = n + 2'd1;
          mode_nxt = slx_pkg::MODE_IDLE;
        end else begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_ERROR, '0, '0, slx_pkg::ERR_UNKNOWN, tok_nxt);
          n = n + 2'd1;
          mode_nxt = slx_pkg::MODE_HALTED; errs_nxt = 1'b1;
          if (c == 8'h00) begin
            r[n] = slx_pkg::mk_res(slx_pkg::RK_END, '0, '0, 1'b0, cur_nxt); n = n + 2'd1;
            mode_nxt = slx_pkg::MODE_IDLE; held_nxt = slx_pkg::HO_NONE; esc_nxt = 1'b0;
            sop_nxt = 1'b0; cur_nxt = slx_pkg::LINE_W'(1); tok_nxt = slx_pkg::LINE_W'(1);
            nlen_nxt = '0; idl_nxt = '0; kw_nxt = '1; errs_nxt = 1'b0;
          end
        end
      end
      slx_pkg::MODE_HELD: begin
        held_nxt = slx_pkg::HO_NONE;
        case (held_r)
          slx_pkg::HO_PLUS: begin
            match = (c == "+"); pair_t = slx_pkg::T_INC; single_t = slx_pkg::T_PLUS;
          end
          slx_pkg::HO_MIN: begin
            match = (c == "-"); pair_t = slx_pkg::T_DEC; single_t = slx_pkg::T_MINUS;
          end
          slx_pkg::HO_EQ: begin
            single_t = slx_pkg::T_ASSIGN;
          end
          slx_pkg::HO_EQ2: begin
            match = (c == "="); pair_t = slx_pkg::T_EQQ; single_t = slx_pkg::T_EQ;
          end
          slx_pkg::HO_GT: begin
            match = (c == "="); pair_t = slx_pkg::T_GE; single_t = slx_pkg::T_GT;
          end
          slx_pkg::HO_LT: begin
            match = (c == "="); pair_t = slx_pkg::T_LE; single_t = slx_pkg::T_LT;
          end
          default: begin
            match = (c == "="); pair_t = slx_pkg::T_NE; single_t = slx_pkg::T_NOT;
          end
        endcase
        if (held_r == slx_pkg::HO_EQ && c == "=") begin
          held_nxt = slx_pkg::HO_EQ2;   // "==" may still grow into "==="
        end else if (match) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, pair_t, 1'b0, tok_nxt); n = n + 2'd1;
          mode_nxt = slx_pkg::MODE_IDLE;
        end else begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, single_t, 1'b0, tok_nxt); n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      default: begin
        if (c == 8'h00) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_END, '0, '0, 1'b0, cur_nxt); n = n + 2'd1;
          mode_nxt = slx_pkg::MODE_IDLE; held_nxt = slx_pkg::HO_NONE; esc_nxt = 1'b0;
          sop_nxt = 1'b0; cur_nxt = slx_pkg::LINE_W'(1); tok_nxt = slx_pkg::LINE_W'(1);
          nlen_nxt = '0; idl_nxt = '0; kw_nxt = '1; errs_nxt = 1'b0;
        end
      end
    endcase

    // byte handled as if between tokens
    if (do_idle) begin
      mode_nxt = slx_pkg::MODE_IDLE;
      if (c == 8'h00) begin
        if (sop_nxt) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_STRING, 1'b0, tok_nxt);
          n = n + 2'd1;
        end
        r[n] = slx_pkg::mk_res(slx_pkg::RK_END, '0, '0, 1'b0, cur_nxt); n = n + 2'd1;
        held_nxt = slx_pkg::HO_NONE; esc_nxt = 1'b0;
        sop_nxt = 1'b0; cur_nxt = slx_pkg::LINE_W'(1); tok_nxt = slx_pkg::LINE_W'(1);
        nlen_nxt = '0; idl_nxt = '0; kw_nxt = '1; errs_nxt = 1'b0;
      end else if (c == " " || c == 8'h09 || c == 8'h0d) begin
        mode_nxt = slx_pkg::MODE_IDLE;
      end else if (c == 8'h0a) begin
        if (cur_nxt != slx_pkg::LINE_MAX) cur_nxt = cur_nxt + 1'b1;
      end else if (c == "\"") begin
        if (!sop_nxt) begin
          tok_nxt = cur_nxt; sop_nxt = 1'b1;
        end
        esc_nxt = 1'b0;
        mode_nxt = slx_pkg::MODE_STRING;
      end else if (c == "/") begin
        mode_nxt = slx_pkg::MODE_SLASH;
      end else begin
        if (sop_nxt) begin
          r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_STRING, 1'b0, tok_nxt);
          n = n + 2'd1;
          sop_nxt = 1'b0;
        end
        tok_nxt = cur_nxt;
        case (c)
          "(": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_LPAREN, 1'b0, tok_nxt); n = n + 2'd1; end
          ")": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_RPAREN, 1'b0, tok_nxt); n = n + 2'd1; end
          "[": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_LBRACK, 1'b0, tok_nxt); n = n + 2'd1; end
          "]": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_RBRACK, 1'b0, tok_nxt); n = n + 2'd1; end
          "{": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_LBRACE, 1'b0, tok_nxt); n = n + 2'd1; end
          "}": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_RBRACE, 1'b0, tok_nxt); n = n + 2'd1; end
          ";": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_SEMI, 1'b0, tok_nxt); n = n + 2'd1; end
          ",": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_COMMA, 1'b0, tok_nxt); n = n + 2'd1; end
          ".": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_DOT, 1'b0, tok_nxt); n = n + 2'd1; end
          "*": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_MUL, 1'b0, tok_nxt); n = n + 2'd1; end
          "%": begin r[n] = slx_pkg::mk_res(slx_pkg::RK_TOKEN, '0, slx_pkg::T_MOD, 1'b0, tok_nxt); n = n + 2'd1; end
          "+": begin held_nxt = slx_pkg::HO_PLUS; mode_nxt = slx_pkg::MODE_HELD; end
          "-": begin held_nxt = slx_pkg::HO_MIN;  mode_nxt = slx_pkg::MODE_HELD; end
          "=": begin held_nxt = slx_pkg::HO_EQ;   mode_nxt = slx_pkg::MODE_HELD; end
          ">": begin held_nxt = slx_pkg::HO_GT;   mode_nxt = slx_pkg::MODE_HELD; end
          "<": begin held_nxt = slx_pkg::HO_LT;   mode_nxt = slx_pkg::MODE_HELD; end
          "!": begin held_nxt = slx_pkg::HO_BANG; mode_nxt = slx_pkg::MODE_HELD; end
          "&": mode_nxt = slx_pkg::MODE_AMP;
          "|": mode_nxt = slx_pkg::MODE_PIPE;
          default: begin
            if (slx_pkg::is_digit(c)) begin
              mode_nxt = slx_pkg::MODE_INT;
              nlen_nxt = slx_pkg::NLEN_W'(1);
              r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
            end else if (slx_pkg::is_alpha(c)) begin
              mode_nxt = slx_pkg::MODE_IDENT;
              idl_nxt = '0;
              kw_nxt = '1;
              do_add = 1'b1;
            end else begin
              r[n] = slx_pkg::mk_res(slx_pkg::RK_ERROR, '0, '0, slx_pkg::ERR_UNKNOWN, tok_nxt);
              n = n + 2'd1;
              mode_nxt = slx_pkg::MODE_HALTED; errs_nxt = 1'b1;
            end
          end
        endcase
      end
    end

    // append a character to an identifier and prune keyword candidates
    if (do_add) begin
      for (int k = 0; k < slx_pkg::KW_N; k++) begin
        if (idl_nxt >= slx_pkg::kw_len(k) || slx_pkg::kw_char(k, idl_nxt) != c)
          kw_nxt[k] = 1'b0;
      end
      if (idl_nxt != 4'd15) idl_nxt = idl_nxt + 4'd1;
      r[n] = slx_pkg::mk_res(slx_pkg::RK_CHAR, c, '0, 1'b0, tok_nxt); n = n + 2'd1;
    end

    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    res_o[0] = r[0];
    res_o[1] = r[1];
    res_o[2] = r[2];
    res_cnt_o = n;
  end

  property p_halt_flag;
    @(posedge clk) disable iff (!rst_n) (mode_r == slx_pkg::MODE_HALTED) |-> errs_r;
  endproperty
  a_halt_flag: assert property (p_halt_flag) else $error("halted without error flag");

  property p_line_nonzero;
    @(posedge clk) disable iff (!rst_n) (cur_r != '0) && (tok_r != '0);
  endproperty
  a_line_nonzero: assert property (p_line_nonzero) else $error("line counter at zero");

  property p_line_mono;
    @(posedge clk) disable iff (!rst_n)
      (step_en && byte_in != 8'h00) |=> (cur_r >= $past(cur_r));
  endproperty
  a_line_mono: assert property (p_line_mono) else $error("line counter went back");

endmodule
`default_nettype wire

[rtl/slx_fifo.sv]
// Result queue: takes up to three results a cycle, gives one a cycle while the reader accepts it.
`timescale 1ns / 1ps
`default_nettype none
module slx_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire slx_pkg::res_t [2:0] wr_data,
  input  wire logic [1:0]          wr_cnt,
  output logic                     room3,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output slx_pkg::res_t            rd_data
);

  slx_pkg::res_t               mem [slx_pkg::RQ_DEPTH];
  logic [slx_pkg::RQ_AW-1:0]   wp_r, rp_r;
  logic [slx_pkg::RQ_AW:0]     cnt_r;
  logic                        pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign room3    = cnt_r <= (slx_pkg::RQ_AW + 1)'(slx_pkg::RQ_DEPTH - 3);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < wr_cnt) mem[wp_r + slx_pkg::RQ_AW'(i)] <= wr_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + slx_pkg::RQ_AW'(wr_cnt);
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (slx_pkg::RQ_AW + 1)'(wr_cnt) - (slx_pkg::RQ_AW + 1)'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) (wr_cnt != 2'd0) |-> room3;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("result queue overflow");

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= (slx_pkg::RQ_AW + 1)'(slx_pkg::RQ_DEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("queue count out of range");

  property p_ptr_track;
    @(posedge clk) disable iff (!rst_n) (wp_r - rp_r) == cnt_r[slx_pkg::RQ_AW-1:0];
  endproperty
  a_ptr_track: assert property (p_ptr_track) else $error("queue pointers disagree");

endmodule
`default_nettype wire
